### hw/rtl/cpmc_pkg.sv
// shared types and constants of the cascaded pi motor controller
package cpmc_pkg;

    localparam int IO_W       = 32;
    localparam int GAIN_W     = 16;
    localparam int LIMIT_W    = 31;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POSITION_GAIN = 3'd0,
        REG_VELOCITY_GAIN = 3'd1,
        REG_ANGLE_GAIN    = 3'd2,
        REG_RATE_GAIN     = 3'd3,
        REG_INTEGRAL_GAIN = 3'd4,
        REG_ANGLE_LIMIT   = 3'd5,
        REG_DRIVE_LIMIT   = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  position_gain;
        logic [GAIN_W-1:0]  velocity_gain;
        logic [GAIN_W-1:0]  angle_gain;
        logic [GAIN_W-1:0]  rate_gain;
        logic [GAIN_W-1:0]  integral_gain;
        logic [LIMIT_W-1:0] angle_limit;
        logic [LIMIT_W-1:0] drive_limit;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        position_gain: 16'd8520,
        velocity_gain: 16'd7782,
        angle_gain:    16'd34120,
        rate_gain:     16'd9093,
        integral_gain: 16'd681,
        angle_limit:   31'd32768,
        drive_limit:   31'd589824
    };

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_POS,
        ST_RND_POS,
        ST_ERR_VEL,
        ST_MUL_VEL,
        ST_RND_VEL,
        ST_CLAMP_ANG,
        ST_ERR_ANG,
        ST_MUL_ANG,
        ST_RND_ANG,
        ST_ERR_RATE,
        ST_MUL_RATE,
        ST_RND_RATE,
        ST_SUM_DRIVE,
        ST_FINISH
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_POS,
        OP_RND,
        OP_ERR_VEL,
        OP_MUL_VEL,
        OP_CLAMP_ANG,
        OP_ERR_ANG,
        OP_MUL_ANG,
        OP_ERR_RATE,
        OP_MUL_RATE,
        OP_RND_MUL_INT,
        OP_SUM_DRIVE,
        OP_FINISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic out_full;
    } dp_stat_t;

endpackage

### hw/rtl/cascaded_pi_motor_controller.sv
// top level of the cascaded pi motor controller
//
// One control tick per input transfer: the target, cart position and velocity, motor angle
// and rate (Q16.16) pass through a position, velocity and angle P loop and a PI rate loop
// with anti-windup, giving the clamped motor drive and a flag that the drive hit its limit.
// After an input transfer the sequencer walks ST_MUL_POS to ST_FINISH, which registers
// the result, and only then returns to idle: no tick is taken while one is in flight.
// On its way it steps all five gain products, their rounding and the error sums through
// one shared multiplier and one shared saturating adder. A finished result waits in the
// output register; if it is still stalled when the next result is ready, the sequencer
// holds until it is taken. Gains and limits are written through the configuration port,
// only while the block is idle; the user must see to this, the block does not enforce it.
module cascaded_pi_motor_controller #(
    parameter int SIGNAL_WIDTH       = 32,
    parameter int GAIN_FRACTION_BITS = 12
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [cpmc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cpmc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic signed [cpmc_pkg::IO_W-1:0] target_raw,
    input  logic signed [cpmc_pkg::IO_W-1:0] cart_position,
    input  logic signed [cpmc_pkg::IO_W-1:0] cart_velocity,
    input  logic signed [cpmc_pkg::IO_W-1:0] motor_angle,
    input  logic signed [cpmc_pkg::IO_W-1:0] motor_rate,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [cpmc_pkg::IO_W-1:0] motor_drive,
    output logic                             drive_clamped
);
    import cpmc_pkg::*;

    cfg_t     cfg;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    cpmc_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cpmc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    cpmc_dp #(
        .SIGNAL_WIDTH       (SIGNAL_WIDTH),
        .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .cmd           (cmd),
        .stat          (stat),
        .target_raw    (target_raw),
        .cart_position (cart_position),
        .cart_velocity (cart_velocity),
        .motor_angle   (motor_angle),
        .motor_rate    (motor_rate),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .motor_drive   (motor_drive),
        .drive_clamped (drive_clamped)
    );

endmodule

### hw/rtl/cpmc_regs.sv
// configuration register file of the cascaded pi motor controller
module cpmc_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cpmc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cpmc_pkg::CFG_DATA_W-1:0] cfg_data,
    output cpmc_pkg::cfg_t                  cfg
);
    import cpmc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_POSITION_GAIN: cfg_next.position_gain = cfg_data[GAIN_W-1:0];
                REG_VELOCITY_GAIN: cfg_next.velocity_gain = cfg_data[GAIN_W-1:0];
                REG_ANGLE_GAIN:    cfg_next.angle_gain    = cfg_data[GAIN_W-1:0];
                REG_RATE_GAIN:     cfg_next.rate_gain     = cfg_data[GAIN_W-1:0];
                REG_INTEGRAL_GAIN: cfg_next.integral_gain = cfg_data[GAIN_W-1:0];
                REG_ANGLE_LIMIT:   cfg_next.angle_limit   = cfg_data[LIMIT_W-1:0];
                REG_DRIVE_LIMIT:   cfg_next.drive_limit   = cfg_data[LIMIT_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### hw/rtl/cpmc_ctrl.sv
// sequencer that steps the shared datapath through the four loops
module cpmc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  cpmc_pkg::dp_stat_t stat,
    output cpmc_pkg::dp_cmd_t  cmd
);
    import cpmc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      state_next = in_valid ? ST_MUL_POS : ST_IDLE;
            ST_MUL_POS:   state_next = ST_RND_POS;
            ST_RND_POS:   state_next = ST_ERR_VEL;
            ST_ERR_VEL:   state_next = ST_MUL_VEL;
            ST_MUL_VEL:   state_next = ST_RND_VEL;
            ST_RND_VEL:   state_next = ST_CLAMP_ANG;
            ST_CLAMP_ANG: state_next = ST_ERR_ANG;
            ST_ERR_ANG:   state_next = ST_MUL_ANG;
            ST_MUL_ANG:   state_next = ST_RND_ANG;
            ST_RND_ANG:   state_next = ST_ERR_RATE;
            ST_ERR_RATE:  state_next = ST_MUL_RATE;
            ST_MUL_RATE:  state_next = ST_RND_RATE;
            ST_RND_RATE:  state_next = ST_SUM_DRIVE;
            ST_SUM_DRIVE: state_next = ST_FINISH;
            ST_FINISH:    state_next = stat.out_full ? ST_FINISH : ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall = (state_reg != ST_IDLE);
        cmd.op   = OP_NONE;
        unique case (state_reg)
            ST_IDLE:      cmd.op = in_valid ? OP_LOAD : OP_NONE;
            ST_MUL_POS:   cmd.op = OP_MUL_POS;
            ST_RND_POS:   cmd.op = OP_RND;
            ST_ERR_VEL:   cmd.op = OP_ERR_VEL;
            ST_MUL_VEL:   cmd.op = OP_MUL_VEL;
            ST_RND_VEL:   cmd.op = OP_RND;
            ST_CLAMP_ANG: cmd.op = OP_CLAMP_ANG;
            ST_ERR_ANG:   cmd.op = OP_ERR_ANG;
            ST_MUL_ANG:   cmd.op = OP_MUL_ANG;
            ST_RND_ANG:   cmd.op = OP_RND;
            ST_ERR_RATE:  cmd.op = OP_ERR_RATE;
            ST_MUL_RATE:  cmd.op = OP_MUL_RATE;
            ST_RND_RATE:  cmd.op = OP_RND_MUL_INT;
            ST_SUM_DRIVE: cmd.op = OP_SUM_DRIVE;
            ST_FINISH:    cmd.op = stat.out_full ? OP_NONE : OP_FINISH;
            default:      cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### hw/rtl/cpmc_dp.sv
// datapath: one shared multiplier, one shared saturating adder, an integral adder, rounding, clamp and output register
module cpmc_dp #(
    parameter int SIGNAL_WIDTH       = 32,
    parameter int GAIN_FRACTION_BITS = 12
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  cpmc_pkg::cfg_t                   cfg,
    input  cpmc_pkg::dp_cmd_t                cmd,
    output cpmc_pkg::dp_stat_t               stat,
    input  logic signed [cpmc_pkg::IO_W-1:0] target_raw,
    input  logic signed [cpmc_pkg::IO_W-1:0] cart_position,
    input  logic signed [cpmc_pkg::IO_W-1:0] cart_velocity,
    input  logic signed [cpmc_pkg::IO_W-1:0] motor_angle,
    input  logic signed [cpmc_pkg::IO_W-1:0] motor_rate,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [cpmc_pkg::IO_W-1:0] motor_drive,
    output logic                             drive_clamped
);
    import cpmc_pkg::*;

    localparam int XW = (SIGNAL_WIDTH > IO_W) ? SIGNAL_WIDTH : IO_W;
    localparam int PW = XW + GAIN_W + 2;
    localparam logic signed [PW-1:0] SMAX =
        {{(PW - SIGNAL_WIDTH + 1){1'b0}}, {(SIGNAL_WIDTH - 1){1'b1}}};
    localparam logic signed [PW-1:0] SMIN = ~SMAX;
    localparam logic signed [PW-1:0] HALF =
        {{(PW - GAIN_FRACTION_BITS){1'b0}}, 1'b1, {(GAIN_FRACTION_BITS - 1){1'b0}}};

    function automatic logic signed [XW-1:0] sat_w(input logic signed [PW-1:0] v);
        logic signed [XW-1:0] r;
        if (v > SMAX)
        begin
            r = SMAX[XW-1:0];
        end
        else if (v < SMIN)
        begin
            r = SMIN[XW-1:0];
        end
        else
        begin
            r = v[XW-1:0];
        end
        return r;
    endfunction

    logic signed [XW-1:0]           e_reg, e_next;
    logic signed [PW-1:0]           prod_reg, prod_next;
    logic signed [XW-1:0]           g_reg, g_next;
    logic signed [XW-1:0]           u_reg, u_next;
    logic signed [IO_W-1:0]         vel_reg, vel_next;
    logic signed [IO_W-1:0]         ang_reg, ang_next;
    logic signed [IO_W-1:0]         rate_reg, rate_next;
    logic signed [SIGNAL_WIDTH-1:0] integ_reg, integ_next;
    logic signed [IO_W-1:0]         drive_reg, drive_next;
    logic                           clamped_reg, clamped_next;
    logic                           out_valid_reg, out_valid_next;

    logic [GAIN_W-1:0]        gain_sel;
    logic signed [GAIN_W:0]   gain_s;
    logic                     mul_en;
    logic signed [PW-1:0]     mul_val;

    logic signed [PW-1:0]     rnd_q;
    logic signed [PW-1:0]     rnd_sh;
    logic signed [XW-1:0]     rnd_val;

    logic signed [PW-1:0]     add_a, add_b, add_sum;
    logic                     add_sub;
    logic signed [XW-1:0]     add_val;

    logic signed [PW-1:0]     int_sum;
    logic signed [XW-1:0]     int_val;

    logic signed [XW-1:0]     clamp_in;
    logic [LIMIT_W-1:0]       clamp_lim;
    logic signed [PW-1:0]     clamp_v, clamp_l, clamp_nl;
    logic signed [XW-1:0]     clamp_out;
    logic                     clamp_hit;

    // shared multiplier
    always_comb
    begin
        gain_sel = '0;
        mul_en   = 1'b0;
        unique case (cmd.op) inside
            OP_MUL_POS:
            begin
                gain_sel = cfg.position_gain;
                mul_en   = 1'b1;
            end
            OP_MUL_VEL:
            begin
                gain_sel = cfg.velocity_gain;
                mul_en   = 1'b1;
            end
            OP_MUL_ANG:
            begin
                gain_sel = cfg.angle_gain;
                mul_en   = 1'b1;
            end
            OP_MUL_RATE:
            begin
                gain_sel = cfg.rate_gain;
                mul_en   = 1'b1;
            end
            OP_RND_MUL_INT:
            begin
                gain_sel = cfg.integral_gain;
                mul_en   = 1'b1;
            end
            default:
            begin
                gain_sel = '0;
                mul_en   = 1'b0;
            end
        endcase
        gain_s  = $signed({1'b0, gain_sel});
        mul_val = PW'(e_reg) * PW'(gain_s);
    end

    // round half up and saturate the registered product
    always_comb
    begin
        rnd_q   = prod_reg + HALF;
        rnd_sh  = rnd_q >>> GAIN_FRACTION_BITS;
        rnd_val = sat_w(rnd_sh);
    end

    // shared saturating adder
    always_comb
    begin
        add_a   = PW'(g_reg);
        add_b   = '0;
        add_sub = 1'b0;
        unique case (cmd.op) inside
            OP_LOAD:
            begin
                add_a   = PW'(cart_position);
                add_b   = PW'(target_raw);
                add_sub = 1'b1;
            end
            OP_ERR_VEL:
            begin
                add_b   = PW'(vel_reg);
                add_sub = 1'b0;
            end
            OP_ERR_ANG:
            begin
                add_b   = PW'(ang_reg);
                add_sub = 1'b1;
            end
            OP_ERR_RATE:
            begin
                add_b   = PW'(rate_reg);
                add_sub = 1'b1;
            end
            OP_SUM_DRIVE:
            begin
                add_b   = PW'(integ_reg);
                add_sub = 1'b0;
            end
            default:
            begin
                add_b   = '0;
                add_sub = 1'b0;
            end
        endcase
        add_sum = add_sub ? (add_a - add_b) : (add_a + add_b);
        add_val = sat_w(add_sum);
    end

    // symmetric clamp, shared by the angle target and the drive
    always_comb
    begin
        if (cmd.op == OP_FINISH)
        begin
            clamp_in  = u_reg;
            clamp_lim = cfg.drive_limit;
        end
        else
        begin
            clamp_in  = g_reg;
            clamp_lim = cfg.angle_limit;
        end
        clamp_v  = PW'(clamp_in);
        clamp_l  = PW'($signed({1'b0, clamp_lim}));
        clamp_nl = -clamp_l;
        if (clamp_v > clamp_l)
        begin
            clamp_out = clamp_l[XW-1:0];
            clamp_hit = 1'b1;
        end
        else if (clamp_v < clamp_nl)
        begin
            clamp_out = clamp_nl[XW-1:0];
            clamp_hit = 1'b1;
        end
        else
        begin
            clamp_out = clamp_in;
            clamp_hit = 1'b0;
        end
    end

    // integral update
    always_comb
    begin
        int_sum = PW'(integ_reg) + PW'(g_reg);
        int_val = sat_w(int_sum);
    end

    always_comb
    begin
        e_next         = e_reg;
        prod_next      = mul_en ? mul_val : prod_reg;
        g_next         = g_reg;
        u_next         = u_reg;
        vel_next       = vel_reg;
        ang_next       = ang_reg;
        rate_next      = rate_reg;
        integ_next     = integ_reg;
        drive_next     = drive_reg;
        clamped_next   = clamped_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (cmd.op) inside
            OP_LOAD:
            begin
                e_next    = add_val;
                vel_next  = cart_velocity;
                ang_next  = motor_angle;
                rate_next = motor_rate;
            end
            OP_ERR_VEL, OP_ERR_ANG, OP_ERR_RATE:
            begin
                e_next = add_val;
            end
            OP_RND, OP_RND_MUL_INT:
            begin
                g_next = rnd_val;
            end
            OP_CLAMP_ANG:
            begin
                g_next = clamp_out;
            end
            OP_SUM_DRIVE:
            begin
                u_next = add_val;
                g_next = rnd_val;
            end
            OP_FINISH:
            begin
                drive_next     = clamp_out[IO_W-1:0];
                clamped_next   = clamp_hit;
                out_valid_next = 1'b1;
                if (!clamp_hit)
                begin
                    integ_next = int_val[SIGNAL_WIDTH-1:0];
                end
            end
            default:
            begin
                e_next = e_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            integ_reg     <= integ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg       <= e_next;
        prod_reg    <= prod_next;
        g_reg       <= g_next;
        u_reg       <= u_next;
        vel_reg     <= vel_next;
        ang_reg     <= ang_next;
        rate_reg    <= rate_next;
        drive_reg   <= drive_next;
        clamped_reg <= clamped_next;
    end

    assign stat.out_full = out_valid_reg && out_stall;
    assign out_valid     = out_valid_reg;
    assign motor_drive   = drive_reg;
    assign drive_clamped = clamped_reg;

endmodule

### hw/rtl/cpmc_checker.sv
// port-level checks of the cascaded pi motor controller and their binding
module cpmc_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_stall,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic signed [cpmc_pkg::IO_W-1:0] motor_drive,
    input logic                             drive_clamped
);

    // one tick at a time: the input side closes right after a transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again right after a transfer");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(motor_drive)
                                      && $stable(drive_clamped)))
    else $error("stalled result changed or vanished");

    // a new result only appears at the end of a tick's sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while the input side was open");

    // no result straight after an input transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> !$rose(out_valid))
    else $error("result appeared one cycle after an input transfer");

endmodule

bind cascaded_pi_motor_controller cpmc_checker u_cpmc_checker (.*);
